// File: rtl/upc_pkg.sv
// shared types, character constants and helper functions for the percent codec
package upc_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_UZ    = 8'h5a;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_LZ    = 8'h7a;

   localparam logic CSR_DECODE_MODE = 1'b0;
   localparam logic CSR_LOWER_HEX   = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   // up to three result bytes of one input beat
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            fin;
   } bundle_type;

   typedef struct packed {
      logic      in_busy;
      logic      advance;
      logic      fin;
      phase_type phase;
   } status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF) ||
             (c >= CHAR_LA && c <= CHAR_LF);
   endfunction

   // valid only when is_hex holds
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      return c[6] ? (c[3:0] + 4'd9) : c[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
      logic [7:0] base;
      base = lower ? CHAR_LA : CHAR_UA;
      if (v < 4'd10) begin
         return CHAR_0 + {4'd0, v};
      end
      return base + {4'd0, v} - 8'd10;
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return (c >= CHAR_UA && c <= CHAR_UZ) || (c >= CHAR_LA && c <= CHAR_LZ) ||
             (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_DASH || c == CHAR_UNDER ||
             c == CHAR_DOT || c == CHAR_TILDE;
   endfunction

endpackage

// File: rtl/upc_req_if.sv
// input channel: one string byte per beat with a final-byte flag
interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       final_byte;

   modport source (output valid, output in_byte, output final_byte, input ready);
   modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

// File: rtl/upc_rsp_if.sv
// result channel: one converted byte per beat with run and string markers
interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       end_of_string;

   modport source (output valid, output out_byte, output last_of_run,
                   output end_of_string, input ready);
   modport sink (input valid, input out_byte, input last_of_run,
                 input end_of_string, output ready);
endinterface

// File: rtl/upc_convert.sv
// input register, escape state and per-byte conversion into a result bundle
module upc_convert
   import upc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   upc_req_if.sink    req,
   input  logic       decode_mode,
   input  logic       lower_hex,
   input  logic       sink_free,
   output logic       load,
   output bundle_type result,
   output status_type status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_fin_ff, in_fin_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       advance;
   logic       accept;

   // conversion of the registered byte
   always_comb begin
      logic [7:0] c;
      logic [1:0] n;
      phase_type  ph;
      logic [7:0] hd;
      c  = in_byte_ff;
      n  = 2'd0;
      ph = PHASE_IDLE;
      hd = held_ff;
      result.bytes = '0;
      if (!decode_mode) begin
         if (is_unreserved(c)) begin
            result.bytes[0] = c;
            n = 2'd1;
         end else begin
            result.bytes[0] = CHAR_PCT;
            result.bytes[1] = hex_char(c[7:4], lower_hex);
            result.bytes[2] = hex_char(c[3:0], lower_hex);
            n = 2'd3;
         end
      end else begin
         case (phase_ff)
            PHASE_PCT: begin
               if (is_hex(c)) begin
                  hd = c;
                  ph = PHASE_DIGIT;
               end else begin
                  result.bytes[n] = CHAR_PCT;
                  n = n + 2'd1;
                  if (c == CHAR_PCT) begin
                     ph = PHASE_PCT;
                  end else begin
                     result.bytes[n] = c;
                     n = n + 2'd1;
                  end
               end
            end
            PHASE_DIGIT: begin
               if (is_hex(c)) begin
                  result.bytes[n] = {hex_value(held_ff), hex_value(c)};
                  n = n + 2'd1;
               end else begin
                  result.bytes[n] = CHAR_PCT;
                  n = n + 2'd1;
                  result.bytes[n] = held_ff;
                  n = n + 2'd1;
                  if (c == CHAR_PCT) begin
                     ph = PHASE_PCT;
                  end else begin
                     result.bytes[n] = c;
                     n = n + 2'd1;
                  end
               end
            end
            default: begin
               if (c == CHAR_PCT) begin
                  ph = PHASE_PCT;
               end else begin
                  result.bytes[n] = c;
                  n = n + 2'd1;
               end
            end
         endcase
         // flush a pending escape on the final byte
         if (in_fin_ff) begin
            if (ph == PHASE_PCT) begin
               result.bytes[n] = CHAR_PCT;
               n = n + 2'd1;
            end else if (ph == PHASE_DIGIT) begin
               result.bytes[n] = CHAR_PCT;
               n = n + 2'd1;
               result.bytes[n] = hd;
               n = n + 2'd1;
            end
            ph = PHASE_IDLE;
         end
      end
      result.count = n;
      result.fin   = in_fin_ff;
      phase_in     = ph;
      held_in      = hd;
   end

   assign advance   = in_valid_ff && (result.count == 2'd0 || sink_free);
   assign load      = advance && (result.count != 2'd0);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_fin_in   = in_fin_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.in_byte;
         in_fin_in   = req.final_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_IDLE;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_fin_ff  <= in_fin_in;
      if (advance) begin
         held_ff <= held_in;
      end
   end

   assign status.in_busy = in_valid_ff;
   assign status.advance = advance;
   assign status.fin     = in_fin_ff;
   assign status.phase   = phase_ff;

endmodule

// File: rtl/upc_serializer.sv
// result register that hands out a bundle one byte per beat
module upc_serializer
   import upc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       free,
   upc_rsp_if.source  rsp
);

   bundle_type bun_ff, bun_in;
   logic       bun_valid_ff, bun_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       fire;

   assign last = (idx_ff == bun_ff.count - 2'd1);
   assign fire = rsp.valid && rsp.ready;
   assign free = !bun_valid_ff || (fire && last);

   assign rsp.valid         = bun_valid_ff;
   assign rsp.out_byte      = bun_ff.bytes[idx_ff];
   assign rsp.last_of_run   = last;
   assign rsp.end_of_string = last && bun_ff.fin;

   always_comb begin
      bun_in       = bun_ff;
      bun_valid_in = bun_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         bun_in       = bundle;
         bun_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (fire) begin
         if (last) begin
            bun_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bun_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         bun_valid_ff <= bun_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bun_ff <= bun_in;
   end

endmodule

// File: rtl/url_percent_codec_unit.sv
// top level of the url percent encoder and decoder
//
// req channel: one string byte per beat, final_byte set on the last byte of a
// string. rsp channel: one converted byte per beat, last_of_run on the last
// byte produced by an input beat, end_of_string on the last byte of a string.
// csr port: csr_wr_en with csr_index 0 sets decode mode, index 1 selects lower
// case hex digits; write only while the block has nothing in flight.
// an accepted byte passes the input register and then the result register
// before its first result beat is valid.
// throughput: one result beat per cycle while rsp is ready, and an input byte
// gives one to three result beats; the result register
// and its byte counter set that rate. bytes that make no result (an escape
// still being gathered) retire without waiting for the result register.
// a new byte is taken into the input register while earlier results drain.
// reset clears the escape state, both csr bits and all valid flags; no
// clearing pass is needed. when rsp stalls, the result register holds, then
// the input register fills and req.ready drops.
module url_percent_codec_unit
   import upc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   upc_req_if.sink   req,
   upc_rsp_if.source rsp,
   input  logic      csr_wr_en,
   input  logic      csr_index,
   input  logic      csr_wr_data
);

   logic       decode_mode_ff, decode_mode_in;
   logic       lower_hex_ff, lower_hex_in;
   logic       load;
   logic       free;
   bundle_type bundle;
   status_type status;

   // csr write decode
   always_comb begin
      decode_mode_in = decode_mode_ff;
      lower_hex_in   = lower_hex_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DECODE_MODE: decode_mode_in = csr_wr_data;
            CSR_LOWER_HEX:   lower_hex_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         lower_hex_ff   <= 1'b0;
      end else begin
         decode_mode_ff <= decode_mode_in;
         lower_hex_ff   <= lower_hex_in;
      end
   end

   // input register plus conversion logic
   upc_convert u_convert (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .decode_mode (decode_mode_ff),
      .lower_hex   (lower_hex_ff),
      .sink_free   (free),
      .load        (load),
      .result      (bundle),
      .status      (status)
   );

   // result register, one byte per beat
   upc_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .bundle (bundle),
      .free   (free),
      .rsp    (rsp)
   );

   // a final byte always leaves no escape pending
   a_fin_clears_phase: assert property (@(posedge clock) disable iff (reset)
      status.advance && status.fin |=> status.phase == PHASE_IDLE)
      else $error("escape still pending after final byte");

   // encode mode never leaves an escape pending
   a_encode_no_phase: assert property (@(posedge clock) disable iff (reset)
      status.advance && !decode_mode_ff |=> status.phase == PHASE_IDLE)
      else $error("escape pending after encode beat");

   // an empty input register always takes a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !status.in_busy |-> req.ready)
      else $error("input stalled with empty input register");

   // end of string only on the last beat of a run
   a_eos_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.end_of_string |-> rsp.last_of_run)
      else $error("end_of_string without last_of_run");

endmodule

// File: verif/tb_url_percent_codec_unit.sv
// testbench for the url percent codec: directed and random strings, scoreboard checked
`timescale 1ns / 100ps

module tb_url_percent_codec_unit
   import upc_pkg::*;
();

   // one converted byte as it should leave the block
   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_string;
   } codec_result_type;

   // one string byte waiting to be sent
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } char_beat_type;

   // mirror of the codec: own copy of the csr bits and the escape state
   class codec_scoreboard;
      bit               decode_mode;
      bit               lower_hex;
      phase_type        phase;
      logic [7:0]       held_digit;
      logic [7:0]       run[$];
      codec_result_type expected_bytes[$];
      int               errors;

      function new();
         decode_mode = 1'b0;
         lower_hex   = 1'b0;
         phase       = PHASE_IDLE;
         held_digit  = 8'h00;
         errors      = 0;
      endfunction

      function void write_reg(logic idx, logic val);
         if (idx == CSR_DECODE_MODE) decode_mode = val;
         else lower_hex = val;
      endfunction

      function bit hex_digit(logic [7:0] c);
         return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
      endfunction

      function logic [3:0] hex_nibble(logic [7:0] c);
         logic [7:0] v;
         if (c <= 8'h39) v = c - 8'h30;
         else if (c <= 8'h46) v = c - 8'h37;
         else v = c - 8'h57;
         return v[3:0];
      endfunction

      function bit unreserved(logic [7:0] c);
         return c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
                          CHAR_DASH, CHAR_UNDER, CHAR_DOT, CHAR_TILDE};
      endfunction

      function logic [7:0] nibble_char(logic [3:0] n);
         if (n < 4'd10) return 8'h30 + {4'd0, n};
         return (lower_hex ? 8'h57 : 8'h37) + {4'd0, n};
      endfunction

      // decode side, no escape open
      function void open_byte(logic [7:0] c);
         if (c == CHAR_PCT) phase = PHASE_PCT;
         else run.push_back(c);
      endfunction

      // predict the converted bytes of one accepted input beat
      function void take_byte(logic [7:0] c, logic fin);
         codec_result_type r;
         run.delete();
         if (!decode_mode) begin
            // any open escape is dropped
            phase = PHASE_IDLE;
            if (unreserved(c)) begin
               run.push_back(c);
            end else begin
               run.push_back(CHAR_PCT);
               run.push_back(nibble_char(c[7:4]));
               run.push_back(nibble_char(c[3:0]));
            end
         end else begin
            case (phase)
               PHASE_PCT: begin
                  if (hex_digit(c)) begin
                     held_digit = c;
                     phase = PHASE_DIGIT;
                  end else begin
                     run.push_back(CHAR_PCT);
                     phase = PHASE_IDLE;
                     open_byte(c);
                  end
               end
               PHASE_DIGIT: begin
                  if (hex_digit(c) && hex_digit(held_digit)) begin
                     run.push_back({hex_nibble(held_digit), hex_nibble(c)});
                     phase = PHASE_IDLE;
                  end else begin
                     run.push_back(CHAR_PCT);
                     run.push_back(held_digit);
                     phase = PHASE_IDLE;
                     open_byte(c);
                  end
               end
               default: begin
                  phase = PHASE_IDLE;
                  open_byte(c);
               end
            endcase
            if (fin) begin
               if (phase == PHASE_PCT) begin
                  run.push_back(CHAR_PCT);
               end else if (phase == PHASE_DIGIT) begin
                  run.push_back(CHAR_PCT);
                  run.push_back(held_digit);
               end
               phase = PHASE_IDLE;
            end
         end
         foreach (run[i]) begin
            r.out_byte      = run[i];
            r.last_of_run   = (i == run.size() - 1);
            r.end_of_string = fin && (i == run.size() - 1);
            expected_bytes.push_back(r);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_byte(logic [7:0] b, logic last, logic eos);
         codec_result_type w;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected beat, out_byte %02h", b));
            return;
         end
         w = expected_bytes.pop_front();
         if (b !== w.out_byte)
            report($sformatf("out_byte expected %02h got %02h", w.out_byte, b));
         if (last !== w.last_of_run)
            report($sformatf("last_of_run expected %0b got %0b on byte %02h",
                             w.last_of_run, last, w.out_byte));
         if (eos !== w.end_of_string)
            report($sformatf("end_of_string expected %0b got %0b on byte %02h",
                             w.end_of_string, eos, w.out_byte));
      endtask
   endclass

   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_CYCLES = 8;
   localparam int PHASE_BEATS  = 50;
   // idling percentages per phase kind: none, sender, receiver, both
   localparam int SEND_IDLE[4] = '{0, 55, 0, 37};
   localparam int RSP_STALL[4] = '{0, 0, 55, 37};

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic csr_wr_data;

   upc_req_if req_ch();
   upc_rsp_if rsp_ch();

   codec_scoreboard sb = new();
   char_beat_type   string_beats[$];
   int              idle_pct;
   int              stall_pct;
   int              cycle_count;

   url_percent_codec_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stalls, changed at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
   end

   // every accepted result beat is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
         sb.check_byte(rsp_ch.out_byte, rsp_ch.last_of_run, rsp_ch.end_of_string);
   end

   task push_beat(logic [7:0] ch, logic fin);
      char_beat_type b;
      b.ch  = ch;
      b.fin = fin;
      string_beats.push_back(b);
   endtask

   task push_text(string s, bit fin_end);
      for (int i = 0; i < s.len(); i++)
         push_beat(s[i], fin_end && (i == s.len() - 1));
   endtask

   function logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return CHAR_0 + 8'(v);
      if (v < 16) return CHAR_LA + 8'(v - 10);
      return CHAR_UA + 8'(v - 16);
   endfunction

   // sometimes a second percent sign, which opens a new escape
   function logic [7:0] random_non_hex();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) return CHAR_PCT;
      c = 8'($urandom_range(0, 255));
      while (sb.hex_digit(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function logic [7:0] random_unreserved();
      int v;
      v = $urandom_range(0, 65);
      if (v < 26) return CHAR_UA + 8'(v);
      if (v < 52) return CHAR_LA + 8'(v - 26);
      if (v < 62) return CHAR_0 + 8'(v - 52);
      case (v)
         62: return CHAR_DASH;
         63: return CHAR_UNDER;
         64: return CHAR_DOT;
         default: return CHAR_TILDE;
      endcase
   endfunction

   // mostly well-formed escapes with some broken and truncated ones
   task add_decode_string();
      int pieces;
      int roll;
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            push_beat(random_unreserved(), 1'b0);
         end else if (roll < 60) begin
            push_beat(CHAR_PCT, 1'b0);
            push_beat(random_hex_char(), 1'b0);
            push_beat(random_hex_char(), 1'b0);
         end else if (roll < 70) begin
            // bad first digit
            push_beat(CHAR_PCT, 1'b0);
            push_beat(random_non_hex(), 1'b0);
         end else if (roll < 80) begin
            // bad second digit
            push_beat(CHAR_PCT, 1'b0);
            push_beat(random_hex_char(), 1'b0);
            push_beat(random_non_hex(), 1'b0);
         end else if (roll < 90) begin
            // truncated escape, flushed if it closes the string
            push_beat(CHAR_PCT, 1'b0);
            if (roll[0]) push_beat(random_hex_char(), 1'b0);
         end else begin
            push_beat(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      string_beats[$].fin = 1'b1;
   endtask

   task add_encode_string();
      int pieces;
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
         if ($urandom_range(0, 1)) push_beat(random_unreserved(), 1'b0);
         else push_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      string_beats[$].fin = 1'b1;
   endtask

   // drive the queued beats, gaps before a beat as the sender idling asks
   task send_beats();
      char_beat_type b;
      while (string_beats.size() != 0) begin
         b = string_beats.pop_front();
         @(negedge clock);
         while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
         req_ch.valid      = 1'b1;
         req_ch.in_byte    = b.ch;
         req_ch.final_byte = b.fin;
         forever begin
            @(posedge clock);
            if (req_ch.ready) break;
         end
         sb.take_byte(b.ch, b.fin);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // all results in, then a quiet wait for a byte that made none
   task wait_quiet();
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic idx, logic val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task set_codec(logic dec, logic lower);
      wait_quiet();
      write_csr(CSR_DECODE_MODE, dec);
      write_csr(CSR_LOWER_HEX, lower);
   endtask

   task set_idling(int kind);
      idle_pct  = SEND_IDLE[kind];
      stall_pct = RSP_STALL[kind];
   endtask

   initial begin
      // known values from time zero
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_DECODE_MODE;
      csr_wr_data       = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = 8'h00;
      req_ch.final_byte = 1'b0;
      rsp_ch.ready      = 1'b0;
      cycle_count       = 0;
      set_idling(0);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // encode, upper case hex: byte extremes, unreserved edges, percent sign
      set_codec(1'b0, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hff, 1'b0);
      push_text("/0Za~%", 1'b0);
      push_beat(8'h80, 1'b1);
      send_beats();

      // lower case hex digits
      set_codec(1'b0, 1'b1);
      push_beat(8'haf, 1'b1);
      send_beats();

      // decode: bad second digit, bad first digit then a new escape,
      // high byte after percent, flush of held digit and of a lone percent
      set_codec(1'b1, 1'b0);
      push_text("%4g", 1'b0);
      push_text("%%7e", 1'b0);
      push_beat(CHAR_PCT, 1'b0);
      push_beat(8'hff, 1'b0);
      push_text("%a", 1'b1);
      push_text("%", 1'b1);
      // escape left open across a switch to encode
      push_text("%4", 1'b0);
      send_beats();
      set_codec(1'b0, 1'b0);
      push_text("x", 1'b1);
      send_beats();

      // random phases: every csr setting, and every idling kind in each mode
      for (int p = 0; p < 8; p++) begin
         set_codec(p[2], p[0] ^ p[1]);
         set_idling(p % 4);
         while (string_beats.size() < PHASE_BEATS) begin
            if (p[2]) add_decode_string();
            else add_encode_string();
         end
         send_beats();
      end

      wait_quiet();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
